### hw/rtl/htok_pkg.sv
// ----------------------------------------------------------------------------
// htok_pkg: shared types and constants for the request tokenizer
// Record and bundle types, token kind codes, character codes and defaults.
// ----------------------------------------------------------------------------
package htok_pkg;

	localparam int DEF_METHOD_LEN  = 16;
	localparam int DEF_PATH_LEN    = 256;
	localparam int DEF_VERSION_LEN = 16;
	localparam int DEF_KEY_LEN     = 64;
	localparam int DEF_VALUE_LEN   = 256;
	localparam int DEF_MAX_HEADERS = 32;

	// bundles held between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// most records one byte can cause
	localparam int MAX_RECS = 3;

	localparam logic [2:0] KIND_METHOD  = 3'd0;
	localparam logic [2:0] KIND_PATH    = 3'd1;
	localparam logic [2:0] KIND_VERSION = 3'd2;
	localparam logic [2:0] KIND_KEY     = 3'd3;
	localparam logic [2:0] KIND_VALUE   = 3'd4;
	localparam logic [2:0] KIND_SUMMARY = 3'd5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] slot;
		logic [7:0] offset;
		logic [7:0] ch;
		logic       tend;
		logic [7:0] len;
		logic       failed;
		logic [5:0] total;
		logic       last;
	} rec_t;

	typedef struct packed {
		logic [1:0]                  cnt;
		rec_t [MAX_RECS-1:0]         recs;
	} bundle_t;

	function automatic rec_t mk_rec(
		input logic [2:0] kind,
		input logic [4:0] slot,
		input logic [7:0] offset,
		input logic [7:0] ch,
		input logic       tend,
		input logic [7:0] len,
		input logic       failed,
		input logic [5:0] total
	);
		rec_t r;
		r.kind   = kind;
		r.slot   = slot;
		r.offset = offset;
		r.ch     = ch;
		r.tend   = tend;
		r.len    = len;
		r.failed = failed;
		r.total  = total;
		r.last   = 1'b0;
		return r;
	endfunction

endpackage

### hw/rtl/htok_in_if.sv
// ----------------------------------------------------------------------------
// htok_in_if: request byte channel
// Valid/ready channel carrying one raw request byte and its end mark.
// ----------------------------------------------------------------------------
interface htok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_request;

	modport source (output valid, output in_byte, output end_of_request, input ready);
	modport sink   (input valid, input in_byte, input end_of_request, output ready);
endinterface

### hw/rtl/htok_out_if.sv
// ----------------------------------------------------------------------------
// htok_out_if: token record channel
// Valid/ready channel carrying one token character, token end or summary.
// ----------------------------------------------------------------------------
interface htok_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_kind;
	logic [4:0] slot;
	logic [7:0] offset;
	logic [7:0] char_out;
	logic       token_end;
	logic [7:0] token_length;
	logic       token_failed;
	logic [5:0] header_total;
	logic       last;

	modport source (
		output valid, output token_kind, output slot, output offset, output char_out,
		output token_end, output token_length, output token_failed, output header_total,
		output last, input ready
	);
	modport sink (
		input valid, input token_kind, input slot, input offset, input char_out,
		input token_end, input token_length, input token_failed, input header_total,
		input last, output ready
	);
endinterface

### hw/rtl/htok_front.sv
// ----------------------------------------------------------------------------
// htok_front: byte classifier and parse state
// Takes one byte per cycle while the queue is not full, updates line/token state and builds the bundle
// of up to three records that the byte causes.
// ----------------------------------------------------------------------------
module htok_front import htok_pkg::*; #(
	parameter int METHOD_LEN  = DEF_METHOD_LEN,
	parameter int PATH_LEN    = DEF_PATH_LEN,
	parameter int VERSION_LEN = DEF_VERSION_LEN,
	parameter int KEY_LEN     = DEF_KEY_LEN,
	parameter int VALUE_LEN   = DEF_VALUE_LEN,
	parameter int MAX_HEADERS = DEF_MAX_HEADERS
) (
	input  logic     clk,
	input  logic     arst_n,
	htok_in_if.sink  req,
	input  logic     q_full,
	output logic     push,
	output bundle_t  push_data
);

	localparam logic [7:0] METHOD_LIM  = 8'(METHOD_LEN - 1);
	localparam logic [7:0] PATH_LIM    = 8'(PATH_LEN - 1);
	localparam logic [7:0] VERSION_LIM = 8'(VERSION_LEN - 1);
	localparam logic [7:0] KEY_LIM     = 8'(KEY_LEN - 1);
	localparam logic [7:0] VALUE_LIM   = 8'(VALUE_LEN - 1);
	localparam logic [5:0] HDR_MAX     = 6'(MAX_HEADERS);

	logic       phase_q, phase_d;
	logic [1:0] sfield_q, sfield_d;
	logic       delim_q, delim_d;
	logic [5:0] hcount_q, hcount_d;
	logic [7:0] offset_q, offset_d;
	logic       lead_q, lead_d;
	logic [7:0] tlen_q, tlen_d;
	logic       colon_q, colon_d;
	logic       sfail_q, sfail_d;
	logic       vseen_q, vseen_d;

	logic       accept;
	logic       is_crlf;
	logic       do_close;
	logic       sfail_now;
	logic [7:0] slim;
	logic [1:0] cnt;
	rec_t [MAX_RECS-1:0] recs;

	assign req.ready = !q_full;
	assign accept    = req.valid && !q_full;
	assign is_crlf   = (req.in_byte == CH_CR) || (req.in_byte == CH_LF);

	always_comb begin
		phase_d  = phase_q;
		sfield_d = sfield_q;
		delim_d  = delim_q;
		hcount_d = hcount_q;
		offset_d = offset_q;
		lead_d   = lead_q;
		tlen_d   = tlen_q;
		colon_d  = colon_q;
		sfail_d  = sfail_q;
		vseen_d  = vseen_q;
		cnt      = 2'd0;
		recs     = '0;
		slim     = VERSION_LIM;
		sfail_now = 1'b0;

		// byte itself
		if (!is_crlf) begin
			if (delim_d) begin
				delim_d  = 1'b0;
				offset_d = 8'd0;
				tlen_d   = 8'd0;
				colon_d  = 1'b0;
				vseen_d  = 1'b0;
				lead_d   = 1'b1;
			end
			if (!phase_d) begin
				if (req.in_byte == CH_SPACE) begin
					if (!lead_d) begin
						if (sfield_d != 2'd3) begin
							recs[cnt] = mk_rec({1'b0, sfield_d}, 5'd0, 8'd0, 8'd0, 1'b1,
								offset_d, 1'b0, 6'd0);
							cnt = cnt + 2'd1;
							sfield_d = sfield_d + 2'd1;
						end
						lead_d = 1'b1;
					end
				end else begin
					if (lead_d) begin
						lead_d   = 1'b0;
						offset_d = 8'd0;
					end
					unique case (sfield_d)
						2'd0:    slim = METHOD_LIM;
						2'd1:    slim = PATH_LIM;
						default: slim = VERSION_LIM;
					endcase
					if (sfield_d != 2'd3 && offset_d < slim) begin
						recs[cnt] = mk_rec({1'b0, sfield_d}, 5'd0, offset_d, req.in_byte,
							1'b0, 8'd0, 1'b0, 6'd0);
						cnt = cnt + 2'd1;
						offset_d = offset_d + 8'd1;
					end
				end
			end else if (hcount_d < HDR_MAX) begin
				if (!colon_d) begin
					if (req.in_byte == CH_COLON) begin
						// leading colons are skipped
						if (!lead_d) begin
							recs[cnt] = mk_rec(KIND_KEY, hcount_d[4:0], 8'd0, 8'd0, 1'b1,
								offset_d, 1'b0, 6'd0);
							cnt = cnt + 2'd1;
							colon_d  = 1'b1;
							lead_d   = 1'b1;
							offset_d = 8'd0;
							tlen_d   = 8'd0;
						end
					end else begin
						lead_d = 1'b0;
						if (offset_d < KEY_LIM) begin
							recs[cnt] = mk_rec(KIND_KEY, hcount_d[4:0], offset_d, req.in_byte,
								1'b0, 8'd0, 1'b0, 6'd0);
							cnt = cnt + 2'd1;
							offset_d = offset_d + 8'd1;
						end
					end
				end else begin
					vseen_d = 1'b1;
					if (!(req.in_byte == CH_SPACE && lead_d)) begin
						lead_d = 1'b0;
						if (offset_d < VALUE_LIM) begin
							recs[cnt] = mk_rec(KIND_VALUE, hcount_d[4:0], offset_d,
								req.in_byte, 1'b0, 8'd0, 1'b0, 6'd0);
							cnt = cnt + 2'd1;
							offset_d = offset_d + 8'd1;
							// trailing blanks stay out of the length
							if (req.in_byte != CH_SPACE) tlen_d = offset_d;
						end
					end
				end
			end
		end

		// line close, on a line break or at end of request
		do_close = is_crlf ? !delim_q : req.end_of_request;
		if (do_close) begin
			if (!phase_d) begin
				if (!lead_d) begin
					if (sfield_d != 2'd3) begin
						sfail_now = (sfield_d != 2'd2);
						recs[cnt] = mk_rec({1'b0, sfield_d}, 5'd0, 8'd0, 8'd0, 1'b1,
							offset_d, sfail_now, 6'd0);
						cnt = cnt + 2'd1;
						if (sfail_now) sfail_d = 1'b1;
						sfield_d = sfield_d + 2'd1;
					end
					lead_d = 1'b1;
				end else if (sfield_d != 2'd3) begin
					recs[cnt] = mk_rec({1'b0, sfield_d}, 5'd0, 8'd0, 8'd0, 1'b1,
						8'd0, 1'b1, 6'd0);
					cnt = cnt + 2'd1;
					sfail_d = 1'b1;
				end
				phase_d = 1'b1;
			end else if (hcount_d < HDR_MAX) begin
				if (!colon_d) begin
					recs[cnt] = mk_rec(KIND_KEY, hcount_d[4:0], 8'd0, 8'd0, 1'b1,
						offset_d, 1'b1, 6'd0);
					cnt = cnt + 2'd1;
				end else if (!vseen_d) begin
					recs[cnt] = mk_rec(KIND_VALUE, hcount_d[4:0], 8'd0, 8'd0, 1'b1,
						8'd0, 1'b1, 6'd0);
					cnt = cnt + 2'd1;
				end else begin
					recs[cnt] = mk_rec(KIND_VALUE, hcount_d[4:0], 8'd0, 8'd0, 1'b1,
						tlen_d, 1'b0, 6'd0);
					cnt = cnt + 2'd1;
					hcount_d = hcount_d + 6'd1;
				end
			end
			delim_d = 1'b1;
		end

		if (req.end_of_request) begin
			recs[cnt] = mk_rec(KIND_SUMMARY, 5'd0, 8'd0, 8'd0, 1'b0, 8'd0,
				sfail_d || !phase_d, hcount_d);
			cnt = cnt + 2'd1;
			phase_d  = 1'b0;
			sfield_d = 2'd0;
			delim_d  = 1'b1;
			hcount_d = 6'd0;
			offset_d = 8'd0;
			lead_d   = 1'b1;
			tlen_d   = 8'd0;
			colon_d  = 1'b0;
			sfail_d  = 1'b0;
			vseen_d  = 1'b0;
		end

		if (cnt != 2'd0) recs[cnt - 2'd1].last = 1'b1;
	end

	assign push           = accept && (cnt != 2'd0);
	assign push_data.cnt  = cnt;
	assign push_data.recs = recs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			sfield_q <= 2'd0;
			delim_q  <= 1'b1;
			hcount_q <= 6'd0;
			offset_q <= 8'd0;
			lead_q   <= 1'b1;
			tlen_q   <= 8'd0;
			colon_q  <= 1'b0;
			sfail_q  <= 1'b0;
			vseen_q  <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			sfield_q <= sfield_d;
			delim_q  <= delim_d;
			hcount_q <= hcount_d;
			offset_q <= offset_d;
			lead_q   <= lead_d;
			tlen_q   <= tlen_d;
			colon_q  <= colon_d;
			sfail_q  <= sfail_d;
			vseen_q  <= vseen_d;
		end
	end

endmodule

### hw/rtl/htok_queue.sv
// ----------------------------------------------------------------------------
// htok_queue: record bundle queue
// Short first-in first-out store of bundles between front and back.
// ----------------------------------------------------------------------------
module htok_queue import htok_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output bundle_t head
);

	bundle_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wptr_q;
	logic [QPTR_W-1:0]    rptr_q;
	logic [QPTR_W:0]      count_q;

	assign full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

### hw/rtl/htok_back.sv
// ----------------------------------------------------------------------------
// htok_back: record serialiser
// Walks the records of the head bundle and presents them one word per cycle
// while tok takes them, through an output register.
// ----------------------------------------------------------------------------
module htok_back import htok_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  bundle_t   head,
	output logic      pop,
	htok_out_if.source tok
);

	logic [1:0] idx_q;
	logic       valid_q;
	rec_t       rec_q;
	logic       load;
	logic       at_last;

	assign load    = !valid_q || tok.ready;
	assign at_last = (idx_q == head.cnt - 2'd1);
	assign pop     = load && !empty && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) rec_q <= head.recs[idx_q];
	end

	assign tok.valid        = valid_q;
	assign tok.token_kind   = rec_q.kind;
	assign tok.slot         = rec_q.slot;
	assign tok.offset       = rec_q.offset;
	assign tok.char_out     = rec_q.ch;
	assign tok.token_end    = rec_q.tend;
	assign tok.token_length = rec_q.len;
	assign tok.token_failed = rec_q.failed;
	assign tok.header_total = rec_q.total;
	assign tok.last         = rec_q.last;

endmodule

### hw/rtl/http_request_tokenizer.sv
// ----------------------------------------------------------------------------
// http_request_tokenizer: byte-wise request line and header tokenizer
// Splits request text into method, path, version and header key/value
// records, closed by a summary record per request.
// ----------------------------------------------------------------------------
// req carries one request byte per word, with end_of_request on the final
// byte. tok carries one record per word: a token character, a token end
// with its length and fail flag, or the request summary; last marks the
// final record caused by a byte.
// Throughput: one byte per cycle while each byte yields at most one record
// and tok is ready. A byte yielding several records sends them in turn;
// only the final byte of a request can yield up to three. The output port
// sets the rate. The records of a byte are written to the queue at the edge
// that takes the byte and reach tok through the output register.
// A four-bundle queue decouples the parser from the output; when tok stalls
// the queue fills and req.ready drops, and no record is lost.
// Reset clears the parse state, empties the queue and drops tok.valid.
// ----------------------------------------------------------------------------
module http_request_tokenizer import htok_pkg::*; #(
	parameter int METHOD_LEN  = DEF_METHOD_LEN,
	parameter int PATH_LEN    = DEF_PATH_LEN,
	parameter int VERSION_LEN = DEF_VERSION_LEN,
	parameter int KEY_LEN     = DEF_KEY_LEN,
	parameter int VALUE_LEN   = DEF_VALUE_LEN,
	parameter int MAX_HEADERS = DEF_MAX_HEADERS
) (
	input  logic       clk,
	input  logic       arst_n,
	htok_in_if.sink    req,
	htok_out_if.source tok
);

	logic    push;
	logic    pop;
	logic    full;
	logic    empty;
	bundle_t push_data;
	bundle_t head;

	htok_front #(
		.METHOD_LEN  (METHOD_LEN),
		.PATH_LEN    (PATH_LEN),
		.VERSION_LEN (VERSION_LEN),
		.KEY_LEN     (KEY_LEN),
		.VALUE_LEN   (VALUE_LEN),
		.MAX_HEADERS (MAX_HEADERS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.q_full    (full),
		.push      (push),
		.push_data (push_data)
	);

	htok_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	htok_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.tok    (tok)
	);

endmodule
